// ===== rtl/positional_insert_delete_queue_defines.svh =====
// assertion macros shared by the rtl
`ifndef POSITIONAL_INSERT_DELETE_QUEUE_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_QUEUE_DEFINES_SVH

// same-cycle implication under reset
`define PIDQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pidq assertion failed");

// next-cycle implication under reset
`define PIDQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pidq assertion failed");

`endif

// ===== rtl/pidq_pkg.sv =====
package pidq_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } pidq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } pidq_status_t;

    localparam int NameW  = 64;
    localparam int ByteW  = 8;
    localparam int PosW   = 3;
    localparam int CountW = 4;

    typedef struct packed {
        logic [NameW-1:0] name;
        logic [ByteW-1:0] sex;
        logic [ByteW-1:0] age;
    } pidq_rec_t;

    // broadcast to every cell
    typedef struct packed {
        logic              ins_en;
        logic              rem_en;
        logic [CountW-1:0] at;
        logic [CountW-1:0] count;
        pidq_rec_t         rec;
    } pidq_cell_ctl_t;

endpackage

// ===== rtl/positional_insert_delete_queue.sv =====
// Ordered record queue with insert, remove, append and read at a position.
// Every accepted item gives one result item. An item is taken and its
// result sits in the output register in the next cycle; a new item is
// accepted every cycle while the result side keeps up, so the rate is one
// item per clock. The records live in a row of DEPTH cells; on each accepted
// item every cell loads, takes its left or right neighbor, or holds, all in
// the same edge. Slots that were never written hold unknown data, but they
// are never returned. No clearing pass is needed after reset.
module positional_insert_delete_queue #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // position, record_name, record_sex, record_age, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // entry_count, out_name, out_sex, out_age, zero pad
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import pidq_pkg::*;

    `include "positional_insert_delete_queue_defines.svh"

    localparam int CapMax = (DEPTH > 15) ? 15 : DEPTH;
    localparam int RdN    = (DEPTH < 8) ? DEPTH : 8;

    logic [CountW-1:0] cap_reg;
    logic [CountW-1:0] cap_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pidq_status_t      status_reg;
    pidq_status_t      status_next;
    logic [CountW-1:0] out_count_reg;
    pidq_rec_t         out_rec_reg;
    pidq_rec_t         out_rec_next;

    pidq_op_t          op;
    logic [PosW-1:0]   pos;
    pidq_rec_t         in_rec;
    logic              accept;
    logic [CountW-1:0] cap_eff;
    logic [CountW-1:0] at;
    logic              is_add;
    logic              full;
    logic              add_range_err;
    logic              get_range_err;
    logic              ins_ok;
    logic              get_ok;
    pidq_rec_t         rd_rec;
    pidq_cell_ctl_t    ctl;
    pidq_rec_t         cell_q [DEPTH];

    assign op          = pidq_op_t'(s_tuser);
    assign pos         = s_tdata[2:0];
    assign in_rec.name = s_tdata[66:3];
    assign in_rec.sex  = s_tdata[74:67];
    assign in_rec.age  = s_tdata[82:75];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cap_eff = (int'(cap_reg) > CapMax) ? CountW'(CapMax) : cap_reg;
    assign is_add  = (op == OP_APPEND) || (op == OP_INSERT);
    assign at      = (op == OP_APPEND) ? count_reg : {1'b0, pos};
    assign full    = count_reg >= cap_eff;

    assign add_range_err = at > count_reg;
    assign get_range_err = {1'b0, pos} >= count_reg;
    assign ins_ok        = is_add && !full && !add_range_err;
    assign get_ok        = !is_add && !get_range_err;

    always_comb begin
        rd_rec = '0;
        for (int i = 0; i < RdN; i++) begin
            if (pos == PosW'(i)) begin
                rd_rec = cell_q[i];
            end
        end
    end

    always_comb begin
        ctl.ins_en = accept && ins_ok;
        ctl.rem_en = accept && get_ok && (op == OP_REMOVE);
        ctl.at     = at;
        ctl.count  = count_reg;
        ctl.rec    = in_rec;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pidq_rec_t left_rec;
        pidq_rec_t right_rec;
        if (g == 0) begin : g_first
            assign left_rec = cell_q[g];
        end else begin : g_mid
            assign left_rec = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_rec = cell_q[g];
        end else begin : g_inner
            assign right_rec = cell_q[g+1];
        end
        pidq_cell #(
            .IDX(g)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .rec       (cell_q[g])
        );
    end

    always_comb begin
        cap_next       = cap_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        out_rec_next   = out_rec_reg;
        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next = 1'b1;
            out_rec_next   = '0;
            if (is_add) begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (add_range_err) begin
                    status_next = ST_RANGE;
                end else begin
                    status_next = ST_OK;
                    count_next  = count_reg + CountW'(1);
                end
            end else begin
                if (get_range_err) begin
                    status_next = ST_RANGE;
                end else begin
                    status_next  = ST_OK;
                    out_rec_next = rd_rec;
                    if (op == OP_REMOVE) begin
                        count_next = count_reg - CountW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CountW'(5);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end else begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_count_reg <= count_next;
        out_rec_reg   <= out_rec_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0, out_rec_reg.age, out_rec_reg.sex, out_rec_reg.name,
                       out_count_reg};

    `PIDQ_ASSERT_NEXT(a_full_holds_count, accept && is_add && full, $stable(count_reg))
    `PIDQ_ASSERT_NEXT(a_insert_grows, accept && ins_ok,
        count_reg == $past(count_reg) + CountW'(1))
    `PIDQ_ASSERT_NOW(a_error_no_record, m_tvalid && (m_tuser != ST_OK), m_tdata[83:4] == '0)
    `PIDQ_ASSERT_NOW(a_stall_only_when_blocked, !s_tready, m_tvalid && !m_tready)

endmodule

// ===== rtl/pidq_cell.sv =====
module pidq_cell #(
    parameter int IDX = 0
) (
    input  logic                    aclk,
    input  pidq_pkg::pidq_cell_ctl_t ctl,
    input  pidq_pkg::pidq_rec_t     left_rec,
    input  pidq_pkg::pidq_rec_t     right_rec,
    output pidq_pkg::pidq_rec_t     rec
);
    import pidq_pkg::*;

    pidq_rec_t rec_reg;
    pidq_rec_t rec_next;

    logic take_load;
    logic take_left;
    logic take_right;

    assign take_load  = ctl.ins_en && (IDX == int'(ctl.at));
    assign take_left  = ctl.ins_en && (IDX > int'(ctl.at)) && (IDX <= int'(ctl.count));
    assign take_right = ctl.rem_en && (IDX >= int'(ctl.at)) && (IDX + 1 < int'(ctl.count));

    always_comb begin
        rec_next = rec_reg;
        if (take_load) begin
            rec_next = ctl.rec;
        end else if (take_left) begin
            rec_next = left_rec;
        end else if (take_right) begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule
